### design/lgg_pkg.sv
// ----------------------------------------------------------------------------
// lgg_pkg: shared types and constants of the lift/gamma/gain grade
// Field widths, config codes, stage counts and the exp factor table.
// ----------------------------------------------------------------------------
package lgg_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int LOG_FRAC     = 24;
    localparam int MANT_BITS    = 32;
    localparam int GAIN_BITS    = 16;
    localparam int LEVEL_BITS   = 14;
    localparam int GAMMA_BITS   = 16;
    localparam int EXP_BITS     = 6;
    localparam int Y_BITS       = EXP_BITS + LOG_FRAC;
    localparam int NUM_BITS     = Y_BITS + 12;
    localparam int N_BITS       = $clog2(SAMPLE_BITS + 1);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam int LOG_LAT  = 5 + LOG_FRAC;
    localparam int DIV_LAT  = NUM_BITS + 1;
    localparam int EXP_LAT  = LOG_FRAC + 2;
    localparam int PIPE_LAT = LOG_LAT + DIV_LAT + EXP_LAT;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_LIFT   = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_GAMMA  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red_in;
        logic [SAMPLE_BITS-1:0] green_in;
        logic [SAMPLE_BITS-1:0] blue_in;
        logic [SAMPLE_BITS-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red_out;
        logic [SAMPLE_BITS-1:0] green_out;
        logic [SAMPLE_BITS-1:0] blue_out;
        logic [SAMPLE_BITS-1:0] alpha_out;
    } t_pix_out;

    // zero: result forced to 0, sat: result forced to full scale
    typedef struct packed {
        logic zero;
        logic sat;
    } t_flags;

    // 2^(-2^-k) in Q1.31: k-fold floor square root starting from one half
    function automatic logic [MANT_BITS-1:0] exp_factor(input int k);
        logic [63:0] c;
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bt;
        c = 64'd1 << 30;
        for (int j = 1; j <= k; j++) begin
            x   = c << 31;
            res = 64'd0;
            for (int b = 0; b < 32; b++) begin
                bt = 64'd1 << (62 - 2 * b);
                if (x >= res + bt) begin
                    x   = x - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
            end
            c = res;
        end
        return c[MANT_BITS-1:0];
    endfunction

endpackage

### design/lgg_log.sv
// ----------------------------------------------------------------------------
// lgg_log: gain, lift and offset, then -log2 of the graded base
// Five arithmetic stages and one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module lgg_log
    import lgg_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic [GAIN_BITS-1:0]         i_gain,
    input  logic signed [LEVEL_BITS-1:0] i_lift,
    input  logic signed [LEVEL_BITS-1:0] i_offset,
    input  logic [GAMMA_BITS-1:0]        i_gamma,
    output logic [EXP_BITS-1:0]          o_exp,
    output logic [LOG_FRAC-1:0]          o_frac,
    output t_flags                       o_flags
);

    localparam int VW = SAMPLE_BITS + GAIN_BITS;
    localparam int TW = SAMPLE_BITS + 32;
    localparam logic [VW-1:0] ONE_V = VW'(1) << (SAMPLE_BITS + 12);

    logic [VW-1:0]        r_v;
    logic [VW-1:0]        r_v2;
    logic signed [TW-2:0] r_lv;
    logic signed [TW-1:0] r_t;
    logic [MANT_BITS-1:0] r_tm;
    logic [4:0]           r_p;
    t_flags               r_f4;

    logic [MANT_BITS-1:0] r_m  [0:LOG_FRAC];
    logic [LOG_FRAC-1:0]  r_fb [0:LOG_FRAC];
    logic [EXP_BITS-1:0]  r_e  [0:LOG_FRAC];
    t_flags               r_fl [0:LOG_FRAC];

    logic signed [VW:0]   n_omv;
    logic signed [TW-2:0] n_lv;
    logic signed [TW-1:0] n_t;
    logic                 n_pos;
    logic                 n_hi;
    logic [MANT_BITS-1:0] n_tm;
    logic [4:0]           n_p;
    t_flags               n_f4;

    always_comb begin
        n_omv = $signed({1'b0, ONE_V}) - $signed({1'b0, r_v});
        n_lv  = i_lift * n_omv;
        n_t   = $signed({4'b0, r_v2, 12'b0})
              + $signed({r_lv[TW-2], r_lv})
              + $signed({{6{i_offset[LEVEL_BITS-1]}}, i_offset, {(SAMPLE_BITS + 12){1'b0}}});
        n_pos = !r_t[TW-1] && (r_t != '0);
        n_hi  = (r_t[TW-1:SAMPLE_BITS+24] != '0);
        n_tm  = r_t[SAMPLE_BITS+23:SAMPLE_BITS-8];
        n_p   = 5'd0;
        for (int b = 0; b < MANT_BITS; b++) begin
            if (n_tm[b]) n_p = 5'(b);
        end
        n_f4.sat  = n_pos && n_hi;
        n_f4.zero = !(n_pos && n_hi) && (!n_pos || n_tm == '0 || i_gamma == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v     <= VW'(i_sample) * VW'(i_gain);
            r_v2    <= r_v;
            r_lv    <= n_lv;
            r_t     <= n_t;
            r_tm    <= n_tm;
            r_p     <= n_p;
            r_f4    <= n_f4;
            // normalize so the leading one sits at bit 31
            r_m[0]  <= r_tm << (5'd31 - r_p);
            r_e[0]  <= EXP_BITS'(6'd32 - {1'b0, r_p});
            r_fb[0] <= '0;
            r_fl[0] <= r_f4;
        end
    end

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
        logic [2*MANT_BITS-1:0] n_sq;
        logic [MANT_BITS:0]     n_w;
        assign n_sq = r_m[k-1] * r_m[k-1];
        assign n_w  = n_sq[2*MANT_BITS-1:MANT_BITS-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]  <= n_w[MANT_BITS] ? n_w[MANT_BITS:1] : n_w[MANT_BITS-1:0];
                r_fb[k] <= {r_fb[k-1][LOG_FRAC-2:0], n_w[MANT_BITS]};
                r_e[k]  <= r_e[k-1];
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    assign o_exp   = r_e[LOG_FRAC];
    assign o_frac  = r_fb[LOG_FRAC];
    assign o_flags = r_fl[LOG_FRAC];

endmodule

### design/lgg_div.sv
// ----------------------------------------------------------------------------
// lgg_div: exponent scaling, z = L * 4096 / gamma
// Restoring divider unrolled one quotient bit per stage.
// ----------------------------------------------------------------------------
module lgg_div
    import lgg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [EXP_BITS-1:0]   i_exp,
    input  logic [LOG_FRAC-1:0]   i_frac,
    input  t_flags                i_flags,
    input  logic [GAMMA_BITS-1:0] i_gamma,
    output logic [NUM_BITS-1:0]   o_z,
    output t_flags                o_flags
);

    logic [NUM_BITS-1:0]   r_num [0:NUM_BITS];
    logic [NUM_BITS-1:0]   r_q   [0:NUM_BITS];
    logic [GAMMA_BITS-1:0] r_rem [0:NUM_BITS];
    t_flags                r_fl  [0:NUM_BITS];

    logic [Y_BITS-1:0] n_y;
    assign n_y = {i_exp, {LOG_FRAC{1'b0}}} - {{EXP_BITS{1'b0}}, i_frac};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= {n_y, 12'b0};
            r_q[0]   <= '0;
            r_rem[0] <= '0;
            r_fl[0]  <= i_flags;
        end
    end

    for (genvar i = 1; i <= NUM_BITS; i++) begin : g_bit
        logic [GAMMA_BITS:0] n_trial;
        logic                n_ge;
        logic [GAMMA_BITS:0] n_diff;
        assign n_trial = {r_rem[i-1], r_num[i-1][NUM_BITS-1]};
        assign n_ge    = n_trial >= {1'b0, i_gamma};
        assign n_diff  = n_trial - {1'b0, i_gamma};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[i] <= {r_num[i-1][NUM_BITS-2:0], 1'b0};
                r_q[i]   <= {r_q[i-1][NUM_BITS-2:0], n_ge};
                r_rem[i] <= n_ge ? n_diff[GAMMA_BITS-1:0] : n_trial[GAMMA_BITS-1:0];
                r_fl[i]  <= r_fl[i-1];
            end
        end
    end

    assign o_z     = r_q[NUM_BITS];
    assign o_flags = r_fl[NUM_BITS];

endmodule

### design/lgg_exp.sv
// ----------------------------------------------------------------------------
// lgg_exp: 2^-z as a product of constant factors, then round and saturate
// One conditional multiply per fraction bit, one stage for the final shift.
// ----------------------------------------------------------------------------
module lgg_exp
    import lgg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [NUM_BITS-1:0]    i_z,
    input  t_flags                 i_flags,
    output logic [SAMPLE_BITS-1:0] o_res
);

    localparam int IW = NUM_BITS - LOG_FRAC;
    localparam logic [MANT_BITS:0] MAXV = (MANT_BITS+1)'((1 << SAMPLE_BITS) - 1);

    logic [MANT_BITS-1:0]   r_acc [0:LOG_FRAC];
    logic [LOG_FRAC-1:0]    r_r   [0:LOG_FRAC];
    logic [N_BITS-1:0]      r_n   [0:LOG_FRAC];
    t_flags                 r_fl  [0:LOG_FRAC];
    logic [SAMPLE_BITS-1:0] r_res;

    logic   n_big;
    t_flags n_fl0;

    always_comb begin
        n_big      = i_z[NUM_BITS-1:LOG_FRAC] > IW'(SAMPLE_BITS);
        n_fl0.sat  = i_flags.sat;
        n_fl0.zero = i_flags.zero || (n_big && !i_flags.sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= MANT_BITS'(1) << (MANT_BITS - 1);
            r_r[0]   <= i_z[LOG_FRAC-1:0];
            r_n[0]   <= i_z[N_BITS-1+LOG_FRAC:LOG_FRAC];
            r_fl[0]  <= n_fl0;
        end
    end

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_mul
        localparam logic [MANT_BITS-1:0] C_K = exp_factor(k);
        logic [2*MANT_BITS-1:0] n_prod;
        assign n_prod = r_acc[k-1] * C_K;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= r_r[k-1][LOG_FRAC-k] ? n_prod[2*MANT_BITS-2:MANT_BITS-1]
                                                 : r_acc[k-1];
                r_r[k]   <= r_r[k-1];
                r_n[k]   <= r_n[k-1];
                r_fl[k]  <= r_fl[k-1];
            end
        end
    end

    logic [5:0]         n_sh;
    logic [MANT_BITS:0] n_rnd;
    logic [MANT_BITS:0] n_round;
    t_flags             n_flast;

    always_comb begin
        n_flast = r_fl[LOG_FRAC];
        n_sh    = 6'(MANT_BITS - 1 - SAMPLE_BITS) + 6'(r_n[LOG_FRAC]);
        n_rnd   = (MANT_BITS+1)'(1) << (n_sh - 6'd1);
        n_round = ({1'b0, r_acc[LOG_FRAC]} + n_rnd) >> n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_flast.sat || (!n_flast.zero && n_round > MAXV)) begin
                r_res <= MAXV[SAMPLE_BITS-1:0];
            end else if (n_flast.zero) begin
                r_res <= '0;
            end else begin
                r_res <= n_round[SAMPLE_BITS-1:0];
            end
        end
    end

    assign o_res = r_res;

endmodule

### design/lift_gamma_gain_color_grade_core.sv
// ----------------------------------------------------------------------------
// lift_gamma_gain_color_grade_core: per-channel lift/gamma/gain grade
// Grades R, G and B of one RGBA pixel per clock while not stalled; alpha is copied through.
// ----------------------------------------------------------------------------
// Input beats arrive on i_in_valid/o_in_ready carrying a t_pix_in; graded
// beats leave on o_out_valid/i_out_ready as a t_pix_out. Registers are set
// through i_cfg_we/i_cfg_idx/i_cfg_data: gain, lift, offset, gamma; write
// them only while no pixel is in flight.
// Each color channel runs its own pipeline: gain/lift/offset and log2 by
// repeated squaring (29 stages), a bit-per-stage divide by gamma (43 stages),
// and a product of constant power-of-two factors with rounding (26 stages).
// The channel pipelines feed the output register, which drives o_out_valid.
// Throughput is one pixel per clock while the skid register is empty.
// All stages share one advance enable. When the receiver stalls, the output
// register holds and one more beat lands in a skid register; the pipeline
// then freezes and o_in_ready drops until the skid drains. Nothing is lost.
// Reset (synchronous, active low) clears all valid bits and loads the
// registers with gain 1.0, lift 0, offset 0, gamma 1.0.
// ----------------------------------------------------------------------------
module lift_gamma_gain_color_grade_core
    import lgg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_pix_in                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_pix_out                 o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [GAIN_BITS-1:0]         r_gain;
    logic signed [LEVEL_BITS-1:0] r_lift;
    logic signed [LEVEL_BITS-1:0] r_offset;
    logic [GAMMA_BITS-1:0]        r_gamma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_BITS'(4096);
            r_lift   <= '0;
            r_offset <= '0;
            r_gamma  <= GAMMA_BITS'(4096);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_LIFT:   r_lift   <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_OFFSET: r_offset <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_GAMMA:  r_gamma  <= i_cfg_data[GAMMA_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic r_skid_valid;
    logic r_out_valid;
    logic en;

    assign en         = !r_skid_valid;
    assign o_in_ready = i_rst_n && en;

    // valid bits and alpha ride alongside the channel pipelines
    logic [PIPE_LAT-1:0]    r_vld;
    logic [SAMPLE_BITS-1:0] r_alpha [0:PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid && o_in_ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_alpha[0] <= i_in_data.alpha_in;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_alpha[i] <= r_alpha[i-1];
            end
        end
    end

    logic [SAMPLE_BITS-1:0] chan_in  [0:2];
    logic [SAMPLE_BITS-1:0] chan_res [0:2];

    assign chan_in[0] = i_in_data.red_in;
    assign chan_in[1] = i_in_data.green_in;
    assign chan_in[2] = i_in_data.blue_in;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [EXP_BITS-1:0] l_exp;
        logic [LOG_FRAC-1:0] l_frac;
        t_flags              l_flags;
        logic [NUM_BITS-1:0] d_z;
        t_flags              d_flags;

        lgg_log u_log (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_sample (chan_in[c]),
            .i_gain   (r_gain),
            .i_lift   (r_lift),
            .i_offset (r_offset),
            .i_gamma  (r_gamma),
            .o_exp    (l_exp),
            .o_frac   (l_frac),
            .o_flags  (l_flags)
        );

        lgg_div u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_exp   (l_exp),
            .i_frac  (l_frac),
            .i_flags (l_flags),
            .i_gamma (r_gamma),
            .o_z     (d_z),
            .o_flags (d_flags)
        );

        lgg_exp u_exp (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_z     (d_z),
            .i_flags (d_flags),
            .o_res   (chan_res[c])
        );
    end

    t_pix_out emit_data;
    logic     emit;
    logic     take;

    assign emit_data.red_out   = chan_res[0];
    assign emit_data.green_out = chan_res[1];
    assign emit_data.blue_out  = chan_res[2];
    assign emit_data.alpha_out = r_alpha[PIPE_LAT-1];
    assign emit = en && r_vld[PIPE_LAT-1];
    assign take = r_out_valid && i_out_ready;

    t_pix_out r_out;
    t_pix_out r_skid;
    t_pix_out n_out;
    t_pix_out n_skid;
    logic     n_out_valid;
    logic     n_skid_valid;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (emit) begin
            if (!r_out_valid || take) begin
                n_out       = emit_data;
                n_out_valid = 1'b1;
            end else begin
                // receiver stalled: park the beat
                n_skid       = emit_data;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_ready |=> r_skid_valid && $stable(r_skid))
        else $error("parked beat lost during stall");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved while frozen");

endmodule
